// ===== hdl/css_pkg.sv =====
// ----------------------------------------------------------------------------
// css_pkg: shared types and constants of the cocktail shaker sorter
// Holds the list size, data width, queue geometry, word and status types.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int MAX_LEN    = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_LEN);
  localparam int CNT_W      = $clog2(MAX_LEN + 1);

  // Depth of the queues between the parts of the block.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One word: a list element and the flag that closes the list.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
  } item_t;

  // Fill status of a queue.
  typedef struct packed {
    logic full;
    logic empty;
    logic afull;  // fewer than two free slots
  } fifo_stat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_F_START,
    ST_F_FIRST,
    ST_F_RUN,
    ST_F_END,
    ST_B_START,
    ST_B_FIRST,
    ST_B_RUN,
    ST_B_END,
    ST_EMIT
  } sort_state_t;

endpackage

// ===== hdl/css_fifo.sv =====
// ----------------------------------------------------------------------------
// css_fifo: short word queue
// Small first-in first-out buffer of words with full, empty and almost-full.
// ----------------------------------------------------------------------------
module css_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  css_pkg::item_t      din_i,
  input  logic                pop_i,
  output css_pkg::item_t      dout_o,
  output css_pkg::fifo_stat_t stat_o
);

  css_pkg::item_t                  slot_r [css_pkg::QDEPTH];
  logic [css_pkg::QPTR_W-1:0]      wp_r, wp_nxt;
  logic [css_pkg::QPTR_W-1:0]      rp_r, rp_nxt;
  logic [css_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign do_push = push_i && (cnt_r != css_pkg::QCNT_W'(css_pkg::QDEPTH));
  assign do_pop  = pop_i && (cnt_r != '0);

  always_comb begin
    wp_nxt  = do_push ? css_pkg::QPTR_W'(wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? css_pkg::QPTR_W'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = css_pkg::QCNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = css_pkg::QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= din_i;
    end
  end

  assign dout_o       = slot_r[rp_r];
  assign stat_o.full  = (cnt_r == css_pkg::QCNT_W'(css_pkg::QDEPTH));
  assign stat_o.empty = (cnt_r == '0);
  assign stat_o.afull = (cnt_r >= css_pkg::QCNT_W'(css_pkg::QDEPTH - 1));

endmodule

// ===== hdl/css_front.sv =====
// ----------------------------------------------------------------------------
// css_front: input classifier
// Counts words of the current list and marks the word that closes it.
// ----------------------------------------------------------------------------
module css_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_i,
  input  logic signed [css_pkg::DATA_WIDTH-1:0] value_i,
  input  logic                          last_i,
  input  css_pkg::fifo_stat_t           q_stat_i,
  output logic                          full_o,
  output logic                          q_push_o,
  output css_pkg::item_t                q_item_o
);

  logic [css_pkg::IDX_W-1:0] fcnt_r, fcnt_nxt;
  logic                      accept;
  logic                      close;

  assign accept = push_i && !q_stat_i.full;
  // A word that fills the store closes the list just as a marked one does.
  assign close  = last_i || (fcnt_r == css_pkg::IDX_W'(css_pkg::MAX_LEN - 1));

  always_comb begin
    fcnt_nxt = fcnt_r;
    if (accept) begin
      fcnt_nxt = close ? '0 : css_pkg::IDX_W'(fcnt_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
    end else begin
      fcnt_r <= fcnt_nxt;
    end
  end

  assign full_o         = q_stat_i.full;
  assign q_push_o       = accept;
  assign q_item_o.value = value_i;
  assign q_item_o.last  = close;

endmodule

// ===== hdl/css_back.sv =====
// ----------------------------------------------------------------------------
// css_back: sort engine
// Stores a list, sorts it by cocktail shaker passes and reads it out in order.
// ----------------------------------------------------------------------------
module css_back (
  input  logic                clk,
  input  logic                rst_n,
  input  css_pkg::item_t      q_item_i,
  input  css_pkg::fifo_stat_t q_stat_i,
  output logic                q_pop_o,
  input  css_pkg::fifo_stat_t o_stat_i,
  output logic                o_push_o,
  output css_pkg::item_t      o_item_o
);

  localparam int IW = css_pkg::IDX_W;
  localparam int CW = css_pkg::CNT_W;
  localparam int DW = css_pkg::DATA_WIDTH;

  logic signed [DW-1:0] store_r [css_pkg::MAX_LEN];
  logic signed [DW-1:0] rdata_r;

  css_pkg::sort_state_t state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        ek_r, ek_nxt;
  logic [IW-1:0]        lo_r, lo_nxt;
  logic [IW-1:0]        hi_r, hi_nxt;
  logic [IW-1:0]        nlo_r, nlo_nxt;
  logic [IW-1:0]        nhi_r, nhi_nxt;
  logic [IW-1:0]        pos_r, pos_nxt;
  logic signed [DW-1:0] carry_r, carry_nxt;
  logic                 ev_r, ev_nxt;
  logic                 elast_r, elast_nxt;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic signed [DW-1:0] mem_wdata;
  logic                 mem_re;
  logic [IW-1:0]        mem_raddr;

  // The carry register holds the element travelling along the pass; each
  // step compares it with the neighbor just read and writes back the one
  // that stays behind.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ek_nxt    = ek_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    nlo_nxt   = nlo_r;
    nhi_nxt   = nhi_r;
    pos_nxt   = pos_r;
    carry_nxt = carry_r;
    ev_nxt    = 1'b0;
    elast_nxt = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = carry_r;
    mem_re    = 1'b0;
    mem_raddr = pos_r;
    q_pop_o   = 1'b0;

    unique case (state_r)
      css_pkg::ST_LOAD: begin
        if (!q_stat_i.empty) begin
          q_pop_o   = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = cnt_r[IW-1:0];
          mem_wdata = q_item_i.value;
          cnt_nxt   = CW'(cnt_r + 1'b1);
          if (q_item_i.last) begin
            lo_nxt    = '0;
            hi_nxt    = cnt_r[IW-1:0];
            state_nxt = (cnt_r == '0) ? css_pkg::ST_EMIT : css_pkg::ST_F_START;
          end
        end
      end
      css_pkg::ST_F_START: begin
        mem_re    = 1'b1;
        mem_raddr = lo_r;
        nhi_nxt   = lo_r;
        state_nxt = css_pkg::ST_F_FIRST;
      end
      css_pkg::ST_F_FIRST: begin
        carry_nxt = rdata_r;
        pos_nxt   = lo_r;
        mem_re    = 1'b1;
        mem_raddr = IW'(lo_r + 1'b1);
        state_nxt = css_pkg::ST_F_RUN;
      end
      css_pkg::ST_F_RUN: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        if (carry_r > rdata_r) begin
          mem_wdata = rdata_r;
          nhi_nxt   = pos_r;
        end else begin
          mem_wdata = carry_r;
          carry_nxt = rdata_r;
        end
        pos_nxt = IW'(pos_r + 1'b1);
        if (IW'(pos_r + 1'b1) == hi_r) begin
          state_nxt = css_pkg::ST_F_END;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IW'(pos_r + 2'd2);
        end
      end
      css_pkg::ST_F_END: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = carry_r;
        hi_nxt    = nhi_r;
        state_nxt = (lo_r < nhi_r) ? css_pkg::ST_B_START : css_pkg::ST_EMIT;
      end
      css_pkg::ST_B_START: begin
        mem_re    = 1'b1;
        mem_raddr = hi_r;
        nlo_nxt   = hi_r;
        state_nxt = css_pkg::ST_B_FIRST;
      end
      css_pkg::ST_B_FIRST: begin
        carry_nxt = rdata_r;
        pos_nxt   = hi_r;
        mem_re    = 1'b1;
        mem_raddr = IW'(hi_r - 1'b1);
        state_nxt = css_pkg::ST_B_RUN;
      end
      css_pkg::ST_B_RUN: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        if (rdata_r > carry_r) begin
          mem_wdata = rdata_r;
          nlo_nxt   = pos_r;
        end else begin
          mem_wdata = carry_r;
          carry_nxt = rdata_r;
        end
        pos_nxt = IW'(pos_r - 1'b1);
        if (IW'(pos_r - 1'b1) == lo_r) begin
          state_nxt = css_pkg::ST_B_END;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IW'(pos_r - 2'd2);
        end
      end
      css_pkg::ST_B_END: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = carry_r;
        lo_nxt    = nlo_r;
        state_nxt = (nlo_r < hi_r) ? css_pkg::ST_F_START : css_pkg::ST_EMIT;
      end
      css_pkg::ST_EMIT: begin
        if (!o_stat_i.afull) begin
          mem_re    = 1'b1;
          mem_raddr = ek_r[IW-1:0];
          ev_nxt    = 1'b1;
          elast_nxt = (CW'(ek_r + 1'b1) == cnt_r);
          ek_nxt    = CW'(ek_r + 1'b1);
          if (CW'(ek_r + 1'b1) == cnt_r) begin
            ek_nxt    = '0;
            cnt_nxt   = '0;
            state_nxt = css_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = css_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= css_pkg::ST_LOAD;
      cnt_r   <= '0;
      ek_r    <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
      nlo_r   <= '0;
      nhi_r   <= '0;
      pos_r   <= '0;
      ev_r    <= 1'b0;
      elast_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ek_r    <= ek_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      nlo_r   <= nlo_nxt;
      nhi_r   <= nhi_nxt;
      pos_r   <= pos_nxt;
      ev_r    <= ev_nxt;
      elast_r <= elast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
  end

  // Element store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= store_r[mem_raddr];
    end
  end

  assign o_push_o       = ev_r;
  assign o_item_o.value = rdata_r;
  assign o_item_o.last  = elast_r;

endmodule

// ===== hdl/cocktail_shaker_sorter.sv =====
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter: list sorter with queue interfaces
// Collects a list of signed words, sorts it ascending and returns it in order.
// ----------------------------------------------------------------------------
// Usage. Words enter on in_value/in_last and are taken at a rising edge with
// push high and full low. A word with in_last set, or the word that brings
// the list to MAX_LEN entries, closes the list. The sorted list then comes
// out on out_value_res/out_last_res, one word per pop while empty is low;
// out_last_res marks its final word.
// Timing. Loading writes each word to the element store as it leaves the
// input queue. Sorting works in forward and backward passes through the
// element store, which has one write port and one registered read port.
// Reading out gives one word per cycle while the receiver keeps popping.
// Reset (rst_n low at a clock edge) empties both queues and returns the
// engine to loading; any partial list is dropped.
// Stalls. While the receiver does not pop, the four-word result queue fills
// and the read-out pauses; while the engine sorts or reads out, the four-word
// input queue absorbs new words and then raises full.
// ----------------------------------------------------------------------------
module cocktail_shaker_sorter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [css_pkg::DATA_WIDTH-1:0] in_value,
  input  logic                                  in_last,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [css_pkg::DATA_WIDTH-1:0] out_value_res,
  output logic                                  out_last_res
);

  css_pkg::fifo_stat_t iq_stat;
  css_pkg::fifo_stat_t oq_stat;
  css_pkg::item_t      iq_din;
  css_pkg::item_t      iq_dout;
  css_pkg::item_t      oq_din;
  css_pkg::item_t      oq_dout;
  logic                iq_push;
  logic                iq_pop;
  logic                oq_push;

  // Front part: takes words and marks the one that closes the list.
  css_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .value_i  (in_value),
    .last_i   (in_last),
    .q_stat_i (iq_stat),
    .full_o   (full),
    .q_push_o (iq_push),
    .q_item_o (iq_din)
  );

  // The input queue lets loading continue while the engine is busy.
  css_fifo u_in_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (iq_push),
    .din_i  (iq_din),
    .pop_i  (iq_pop),
    .dout_o (iq_dout),
    .stat_o (iq_stat)
  );

  // Back part: stores, sorts and reads out each list.
  css_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item_i (iq_dout),
    .q_stat_i (iq_stat),
    .q_pop_o  (iq_pop),
    .o_stat_i (oq_stat),
    .o_push_o (oq_push),
    .o_item_o (oq_din)
  );

  // The result queue decouples the read-out from the receiver.
  css_fifo u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (oq_push),
    .din_i  (oq_din),
    .pop_i  (pop),
    .dout_o (oq_dout),
    .stat_o (oq_stat)
  );

  assign empty         = oq_stat.empty;
  assign out_value_res = oq_dout.value;
  assign out_last_res  = oq_dout.last;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the cocktail shaker sorter
// Sends lists of signed words through the push/full queue interface and
// checks every sorted word popped from the result queue against an
// in-bench cocktail shaker sort of the same list.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: keeps the list being loaded, sorts it when the list closes
  // and holds the sorted words that the block still owes us.
  class sort_scoreboard;
    logic signed [css_pkg::DATA_WIDTH-1:0] open_list[$];
    css_pkg::item_t sorted_words[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int lists_closed = 0;
    int full_closes = 0;

    // Note a word the block accepted. A word flagged last, or the word that
    // fills the store, closes the list and produces the expected output.
    function void note_word(logic signed [css_pkg::DATA_WIDTH-1:0] value, logic last);
      int lo, hi, next_lo, next_hi, pos;
      logic signed [css_pkg::DATA_WIDTH-1:0] swap_tmp;
      css_pkg::item_t word;
      open_list.push_back(value);
      words_in++;
      if (!last && open_list.size() < css_pkg::MAX_LEN)
        return;
      if (!last)
        full_closes++;
      lists_closed++;
      lo = 0;
      hi = open_list.size() - 1;
      while (lo < hi) begin
        next_lo = hi;
        next_hi = lo;
        for (pos = lo; pos < hi; pos++) begin
          if (open_list[pos] > open_list[pos+1]) begin
            swap_tmp = open_list[pos];
            open_list[pos] = open_list[pos+1];
            open_list[pos+1] = swap_tmp;
            next_hi = pos;
          end
        end
        hi = next_hi;
        for (pos = hi; pos > lo; pos--) begin
          if (open_list[pos-1] > open_list[pos]) begin
            swap_tmp = open_list[pos-1];
            open_list[pos-1] = open_list[pos];
            open_list[pos] = swap_tmp;
            next_lo = pos;
          end
        end
        lo = next_lo;
      end
      foreach (open_list[k]) begin
        word.value = open_list[k];
        word.last  = (k == open_list.size() - 1);
        sorted_words.push_back(word);
      end
      open_list.delete();
    endfunction

    // Compare a popped word with the oldest expected one.
    function void check_result(logic signed [css_pkg::DATA_WIDTH-1:0] value, logic last);
      css_pkg::item_t want;
      words_out++;
      if (sorted_words.size() == 0) begin
        $display("%0t: unexpected word value=%0d last=%0b", $time, value, last);
        errors++;
        return;
      end
      want = sorted_words.pop_front();
      if (value !== want.value) begin
        $display("%0t: value mismatch, expected %0d, actual %0d",
                 $time, want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last flag mismatch, expected %0b, actual %0b",
                 $time, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return sorted_words.size();
    endfunction
  endclass

  // All block inputs start at known values.
  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  push = 1'b0;
  logic signed [css_pkg::DATA_WIDTH-1:0] in_value = '0;
  logic                                  in_last = 1'b0;
  logic                                  pop = 1'b0;
  logic                                  full;
  logic                                  empty;
  logic signed [css_pkg::DATA_WIDTH-1:0] out_value_res;
  logic                                  out_last_res;

  sort_scoreboard board = new();

  // Handshake between the stimulus process and the receiver process.
  logic hold_request = 1'b0;   // ask the receiver for one long hold-off
  logic quiet_tail = 1'b0;     // no idling on either side near the end
  int   hold_left = 0;
  int   holds_done = 0;
  int   drains_done = 0;
  int   full_cycles = 0;
  int   recv_cycle = 0;
  logic recv_busy = 1'b0;
  logic signed [css_pkg::DATA_WIDTH-1:0] prev_pick = '0;

  cocktail_shaker_sorter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_value     (in_value),
    .in_last      (in_last),
    .empty        (empty),
    .pop          (pop),
    .out_value_res(out_value_res),
    .out_last_res (out_last_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("Timeout: block stopped making progress.");
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver. It samples the result port at each rising edge, checks the word
  // when a pop is taken, and then decides whether to pop in the next cycle.
  // Stalls come in random bursts during busy stretches, and whether a stretch
  // is busy or calm is drawn at random. One long hold-off is served on request
  // so that the result queue, the engine and finally the input queue back up.
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      board.check_result(out_value_res, out_last_res);
    if (push && full)
      full_cycles++;
    recv_cycle++;
    if (recv_cycle % 128 == 0)
      recv_busy = ($urandom_range(0, 1) == 1);
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_left = 799;
      holds_done++;
      pop <= 1'b0;
    end else if (!quiet_tail && recv_busy && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 14);
      pop <= 1'b0;
    end else begin
      pop <= rst_n;
    end
  end

  // Pick a list element: full-range noise, small values that collide often, the
  // extremes, zero, minus one, values in -1000..1000 or the previous word again.
  function automatic logic signed [css_pkg::DATA_WIDTH-1:0] pick_value();
    logic signed [css_pkg::DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2:    v = $signed($urandom_range(0, 15)) - 8;
      3: begin
        case ($urandom_range(0, 3))
          0: v = {1'b0, {(css_pkg::DATA_WIDTH-1){1'b1}}};
          1: v = {1'b1, {(css_pkg::DATA_WIDTH-1){1'b0}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      4:    v = prev_pick;
      default: v = $signed($urandom_range(0, 2000)) - 1000;
    endcase
    prev_pick = v;
    return v;
  endfunction

  // Offer one word and hold it until the block takes it. With gap > 0 the
  // sender then drops push and stays quiet for the gap it was given; with gap = 0 push stays
  // high so the next word can follow back to back.
  task automatic send_word(input logic signed [css_pkg::DATA_WIDTH-1:0] value,
                           input logic last, input int gap);
    push     <= 1'b1;
    in_value <= value;
    in_last  <= last;
    do @(posedge clk); while (full);
    board.note_word(value, last);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send a list of random words. The last word carries the last flag unless
  // the caller wants the store-full case to close the list.
  task automatic send_random_list(input int len, input logic flag_end,
                                  input logic idle_on);
    int gap;
    for (int i = 0; i < len; i++) begin
      gap = 0;
      if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0)
        gap = $urandom_range(1, 15);
      send_word(pick_value(), (i == len - 1) && flag_end, gap);
    end
  endtask

  // Stop offering words and wait until every expected word has come back.
  task automatic wait_for_drain();
    push <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
    drains_done++;
  endtask

  initial begin
    int list_no;
    int len;
    int directed_words;
    logic flag_end;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lists. A single word at each extreme, both extremes with zero and
    // minus one, a run of equal words, a strictly descending list and one that is
    // already in order.
    send_word({1'b0, {(css_pkg::DATA_WIDTH-1){1'b1}}}, 1'b1, 0);
    send_word({1'b1, {(css_pkg::DATA_WIDTH-1){1'b0}}}, 1'b1, 0);
    send_word({1'b0, {(css_pkg::DATA_WIDTH-1){1'b1}}}, 1'b0, 0);
    send_word({1'b1, {(css_pkg::DATA_WIDTH-1){1'b0}}}, 1'b0, 0);
    send_word('0, 1'b0, 0);
    send_word('1, 1'b1, 2);
    for (int i = 0; i < 3; i++)
      send_word(5, i == 2, 0);
    for (int i = 7; i >= 1; i--)
      send_word(i, i == 1, 0);
    for (int i = -3; i <= -1; i++)
      send_word(i, i == -1, 0);
    wait_for_drain();
    directed_words = board.words_in;

    // Random lists. Most are short; now and then a full 64-word list is sent,
    // once deliberately without a last flag so the full store closes it.
    list_no = 0;
    while (board.words_in - directed_words < 200) begin
      if (board.words_in - directed_words >= 160)
        quiet_tail <= 1'b1;
      if (list_no == 4) begin
        // Receiver holds off while the sender keeps pushing short lists
        // back to back, so the result queue fills and full rises.
        hold_request <= 1'b1;
        for (int j = 0; j < 6; j++)
          send_random_list(4, 1'b1, 1'b0);
      end else if (list_no == 5) begin
        send_random_list(css_pkg::MAX_LEN, 1'b0, 1'b1);
      end else begin
        if (list_no == 10)
          wait_for_drain();
        flag_end = 1'b1;
        if ($urandom_range(0, 19) == 0) begin
          len = css_pkg::MAX_LEN;
          flag_end = $urandom_range(0, 1);
        end else begin
          len = $urandom_range(1, 12);
        end
        send_random_list(len, flag_end, $urandom_range(0, 1) == 1);
      end
      list_no++;
    end

    // Let everything come back, then give the block a little extra time in
    // case it emits something it should not.
    wait_for_drain();
    repeat (100) @(posedge clk);

    $display("Covered %0d lists (%0d closed by a full store): %0d words in, %0d out.",
             board.lists_closed, board.full_closes, board.words_in, board.words_out);
    $display("Long receiver hold-offs: %0d, sender drains: %0d, cycles with full: %0d.",
             holds_done, drains_done, full_cycles);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d words still expected.",
               board.errors, board.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
